// File: src/spd_pkg.sv
// ----------------------------------------------------------------------------
// spd_pkg
// Shared constants and types for the sensor packet deframer.
// ----------------------------------------------------------------------------
`default_nettype none

package spd_pkg;

    // default sizing
    localparam int MAX_PAYLOAD_DEF = 64;
    localparam int MAX_RUN_DEF     = 8;

    // results per packet are capped by the 5-bit sample index
    localparam int MAX_RESULTS = 32;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 8;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_HEADER_BYTE    = 3'd0,
        REG_HEADER_LENGTH  = 3'd1,
        REG_TAIL_BYTE      = 3'd2,
        REG_TAIL_LENGTH    = 3'd3,
        REG_EXPECTED_BYTES = 3'd4,
        REG_SAMPLE_OFFSET  = 3'd5
    } cfg_reg_t;

    // register reset values
    localparam logic [7:0] HEADER_BYTE_RST    = 8'hFF;
    localparam logic [3:0] HEADER_LENGTH_RST  = 4'd2;
    localparam logic [7:0] TAIL_BYTE_RST      = 8'hFE;
    localparam logic [3:0] TAIL_LENGTH_RST    = 4'd2;
    localparam logic [6:0] EXPECTED_BYTES_RST = 7'd20;
    localparam logic [5:0] SAMPLE_OFFSET_RST  = 6'd2;

endpackage

`default_nettype wire

// File: src/spd_ram.sv
// ----------------------------------------------------------------------------
// spd_ram
// Generic single-write, single-read memory with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module spd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port, holds when not enabled
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// File: src/sensor_packet_deframer.sv
// ----------------------------------------------------------------------------
// sensor_packet_deframer
// Header/tail byte-stream deframer that emits 16-bit samples per packet.
// ----------------------------------------------------------------------------
// One received byte is taken per cycle while the block hunts for a header or
// collects payload. When a tail closes a packet whose payload length matches
// expected_bytes and holds at least one full sample, the block stops taking
// bytes and walks the payload memory through its single read port: it fetches
// the packet id, then for each sample reads the low byte, reads the high byte
// and presents the word, holding while the sink keeps out_ready low. Other
// packets leave the rx input open.
`default_nettype none

module sensor_packet_deframer #(
    parameter int MAX_PAYLOAD = spd_pkg::MAX_PAYLOAD_DEF,
    parameter int MAX_RUN     = spd_pkg::MAX_RUN_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    // configuration
    input  wire logic                           cfg_write,
    input  wire logic [spd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [spd_pkg::CFG_DATA_W-1:0] cfg_data,
    // byte input
    input  wire logic                           in_valid,
    output logic                                in_ready,
    input  wire logic [7:0]                     rx_byte,
    // sample output
    output logic                                out_valid,
    input  wire logic                           out_ready,
    output logic      [7:0]                     packet_id,
    output logic      [4:0]                     sample_index,
    output logic signed [15:0]                  sample_value,
    output logic                                last_sample
);

    import spd_pkg::*;

    localparam int COUNT_SAT = MAX_PAYLOAD + MAX_RUN + 1;
    localparam int CNT_W     = $clog2(COUNT_SAT + 1);
    localparam int RUN_W     = $clog2(MAX_RUN + 1);
    localparam int AW        = $clog2(MAX_PAYLOAD);
    localparam int IW        = $clog2(MAX_PAYLOAD + 4);
    localparam int CMP_W     = IW + 7;
    localparam int SUM_W     = CNT_W + 8;

    typedef enum logic [4:0] {
        ST_RUN = 5'b00001,
        ST_ID  = 5'b00010,
        ST_LO  = 5'b00100,
        ST_HI  = 5'b01000,
        ST_OUT = 5'b10000
    } state_t;

    // configuration registers
    logic [7:0] header_byte_reg;
    logic [3:0] header_length_reg;
    logic [7:0] tail_byte_reg;
    logic [3:0] tail_length_reg;
    logic [6:0] expected_bytes_reg;
    logic [5:0] sample_offset_reg;

    // framing state
    state_t           state_reg, state_next;
    logic             in_packet_reg, in_packet_next;
    logic [RUN_W-1:0] header_run_reg, header_run_next;
    logic [RUN_W-1:0] tail_run_reg, tail_run_next;
    logic [CNT_W-1:0] count_reg, count_next;

    // sample walk state
    logic [IW-1:0]    idx_reg, idx_next;
    logic [4:0]       num_reg, num_next;
    logic [7:0]       id_reg, id_next;
    logic [7:0]       lo_reg, lo_next;

    // memory interface
    logic             wr_en;
    logic [AW-1:0]    wr_addr;
    logic             rd_en;
    logic [AW-1:0]    rd_addr;
    logic [7:0]       rd_data;

    // derived values
    logic [RUN_W-1:0] hlen;
    logic [RUN_W-1:0] tlen;
    logic [CNT_W-1:0] count_inc;
    logic [IW-1:0]    idx_plus1;
    logic [CMP_W-1:0] exp_wide;
    logic [CMP_W-1:0] offset_wide;
    logic             len_ok;
    logic             has_sample;
    logic             is_last;

    // clamp a run length to 1..MAX_RUN
    function automatic logic [RUN_W-1:0] clamp_run(input logic [3:0] len);
        logic [4:0] len5;
        logic [4:0] res;
        len5 = {1'b0, len};
        if (len5 == 5'd0)
        begin
            res = 5'd1;
        end
        else if (len5 > 5'(MAX_RUN))
        begin
            res = 5'(MAX_RUN);
        end
        else
        begin
            res = len5;
        end
        return res[RUN_W-1:0];
    endfunction

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_byte_reg    <= HEADER_BYTE_RST;
            header_length_reg  <= HEADER_LENGTH_RST;
            tail_byte_reg      <= TAIL_BYTE_RST;
            tail_length_reg    <= TAIL_LENGTH_RST;
            expected_bytes_reg <= EXPECTED_BYTES_RST;
            sample_offset_reg  <= SAMPLE_OFFSET_RST;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_HEADER_BYTE:    header_byte_reg    <= cfg_data;
                REG_HEADER_LENGTH:  header_length_reg  <= cfg_data[3:0];
                REG_TAIL_BYTE:      tail_byte_reg      <= cfg_data;
                REG_TAIL_LENGTH:    tail_length_reg    <= cfg_data[3:0];
                REG_EXPECTED_BYTES: expected_bytes_reg <= cfg_data[6:0];
                REG_SAMPLE_OFFSET:  sample_offset_reg  <= cfg_data[5:0];
                default:            ;
            endcase
        end
    end

    // shared derived terms
    assign hlen        = clamp_run(header_length_reg);
    assign tlen        = clamp_run(tail_length_reg);
    assign count_inc   = (count_reg < CNT_W'(COUNT_SAT)) ? count_reg + CNT_W'(1) : count_reg;
    assign idx_plus1   = idx_reg + IW'(1);
    assign exp_wide    = CMP_W'(expected_bytes_reg);
    assign offset_wide = CMP_W'(sample_offset_reg);

    // length check: expected length nonzero and within the store, payload plus tail must equal the closing count
    assign len_ok = (expected_bytes_reg != 7'd0)
                 && (SUM_W'(expected_bytes_reg) <= SUM_W'(MAX_PAYLOAD))
                 && (SUM_W'(count_inc) == SUM_W'(tlen) + SUM_W'(expected_bytes_reg));

    // at least one full sample fits before the end of the payload
    assign has_sample = (offset_wide + CMP_W'(1)) < exp_wide;

    // final sample: next one would not fit, or result cap reached
    assign is_last = ((CMP_W'(idx_reg) + CMP_W'(3)) >= exp_wide)
                  || (num_reg == 5'(MAX_RESULTS - 1));

    // payload store writes while collecting
    assign wr_en   = (state_reg == ST_RUN) && in_valid && in_packet_reg
                  && (count_reg < CNT_W'(MAX_PAYLOAD));
    assign wr_addr = count_reg[AW-1:0];

    // sequencer and framing
    always_comb
    begin
        state_next      = state_reg;
        in_packet_next  = in_packet_reg;
        header_run_next = header_run_reg;
        tail_run_next   = tail_run_reg;
        count_next      = count_reg;
        idx_next        = idx_reg;
        num_next        = num_reg;
        id_next         = id_reg;
        lo_next         = lo_reg;
        rd_en           = 1'b0;
        rd_addr         = '0;

        unique case (state_reg)
            ST_RUN:
            begin
                if (in_valid)
                begin
                    if (!in_packet_reg)
                    begin
                        // header hunt
                        if (rx_byte == header_byte_reg)
                        begin
                            if (header_run_reg + RUN_W'(1) >= hlen)
                            begin
                                in_packet_next  = 1'b1;
                                header_run_next = '0;
                                tail_run_next   = '0;
                                count_next      = '0;
                            end
                            else
                            begin
                                header_run_next = header_run_reg + RUN_W'(1);
                            end
                        end
                        else
                        begin
                            header_run_next = '0;
                        end
                    end
                    else
                    begin
                        // payload and tail detection
                        count_next = count_inc;
                        if (rx_byte != tail_byte_reg)
                        begin
                            tail_run_next = '0;
                        end
                        else if (tail_run_reg + RUN_W'(1) < tlen)
                        begin
                            tail_run_next = tail_run_reg + RUN_W'(1);
                        end
                        else
                        begin
                            in_packet_next  = 1'b0;
                            header_run_next = '0;
                            tail_run_next   = '0;
                            count_next      = '0;
                            if (len_ok && has_sample)
                            begin
                                idx_next   = offset_wide[IW-1:0];
                                num_next   = '0;
                                state_next = ST_ID;
                            end
                        end
                    end
                end
            end
            ST_ID:
            begin
                // fetch payload byte 0
                rd_en      = 1'b1;
                rd_addr    = '0;
                state_next = ST_LO;
            end
            ST_LO:
            begin
                // fetch low byte, first pass also latches the id
                rd_en   = 1'b1;
                rd_addr = idx_reg[AW-1:0];
                if (num_reg == 5'd0)
                begin
                    id_next = rd_data;
                end
                state_next = ST_HI;
            end
            ST_HI:
            begin
                // fetch high byte, latch low byte
                rd_en      = 1'b1;
                rd_addr    = idx_plus1[AW-1:0];
                lo_next    = rd_data;
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (out_ready)
                begin
                    if (is_last)
                    begin
                        state_next = ST_RUN;
                    end
                    else
                    begin
                        idx_next   = idx_reg + IW'(2);
                        num_next   = num_reg + 5'd1;
                        state_next = ST_LO;
                    end
                end
            end
            default:
            begin
                state_next = ST_RUN;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_RUN;
            in_packet_reg  <= 1'b0;
            header_run_reg <= '0;
            tail_run_reg   <= '0;
            count_reg      <= '0;
            num_reg        <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            in_packet_reg  <= in_packet_next;
            header_run_reg <= header_run_next;
            tail_run_reg   <= tail_run_next;
            count_reg      <= count_next;
            num_reg        <= num_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        idx_reg <= idx_next;
        id_reg  <= id_next;
        lo_reg  <= lo_next;
    end

    // payload store
    spd_ram #(
        .WIDTH (8),
        .DEPTH (MAX_PAYLOAD)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (rx_byte),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // handshake and result word; high byte sits in the store's read register
    assign in_ready     = (state_reg == ST_RUN);
    assign out_valid    = (state_reg == ST_OUT);
    assign packet_id    = id_reg;
    assign sample_index = num_reg;
    assign sample_value = signed'({rd_data, lo_reg});
    assign last_sample  = is_last;

endmodule

`default_nettype wire

// File: bench/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for sensor_packet_deframer.
// ----------------------------------------------------------------------------
// A byte stream is pushed into the deframer with bursty valid and a stalling
// sample sink. The stream is mostly well-formed packets with random payload,
// plus wrong-length, empty, overlong and noise sequences. A deframer model in
// the scoreboard tracks the header/tail hunt. It queues the sample words that
// every closed packet should produce, and each sample leaving the block is
// checked against the oldest queued one. Register settings are changed
// between phases while the block is idle, extremes and out-of-range values
// included.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;

    timeunit 1ns;
    timeprecision 1ps;

    import spd_pkg::*;

    localparam int PAYLOAD_MAX   = MAX_PAYLOAD_DEF;
    localparam int RUN_MAX       = MAX_RUN_DEF;
    localparam int COUNT_CAP     = PAYLOAD_MAX + RUN_MAX + 1;
    localparam int TARGET_BYTES  = 470;
    localparam int SETTLE_CYCLES = 20;
    localparam int REPORT_LIMIT  = 10;

    // one sample word as it leaves the block
    typedef struct packed {
        logic        [7:0]  packet_id;
        logic        [4:0]  sample_index;
        logic signed [15:0] sample_value;
        logic               last_sample;
    } sample_t;

    // deframer model and queue of sample words still to come
    class sample_scoreboard;
        logic [7:0] hdr_byte;
        logic [3:0] hdr_len;
        logic [7:0] tl_byte;
        logic [3:0] tl_len;
        logic [6:0] exp_bytes;
        logic [5:0] smp_offset;

        bit         in_pkt;
        int         hdr_run;
        int         tl_run;
        int         pay_count;
        logic [7:0] pay_mem [PAYLOAD_MAX];

        sample_t    pending_samples [$];
        int         mismatches;

        function new();
            hdr_byte   = HEADER_BYTE_RST;
            hdr_len    = HEADER_LENGTH_RST;
            tl_byte    = TAIL_BYTE_RST;
            tl_len     = TAIL_LENGTH_RST;
            exp_bytes  = EXPECTED_BYTES_RST;
            smp_offset = SAMPLE_OFFSET_RST;
            in_pkt     = 0;
            hdr_run    = 0;
            tl_run     = 0;
            pay_count  = 0;
            mismatches = 0;
        endfunction

        function void set_reg(cfg_reg_t r, logic [7:0] v);
            case (r)
                REG_HEADER_BYTE:    hdr_byte   = v;
                REG_HEADER_LENGTH:  hdr_len    = v[3:0];
                REG_TAIL_BYTE:      tl_byte    = v;
                REG_TAIL_LENGTH:    tl_len     = v[3:0];
                REG_EXPECTED_BYTES: exp_bytes  = v[6:0];
                REG_SAMPLE_OFFSET:  smp_offset = v[5:0];
                default: ;
            endcase
        endfunction

        // zero acts as one, anything past the run limit acts as the limit
        function int run_limit(logic [3:0] v);
            if (v == 0)
                return 1;
            if (v > RUN_MAX)
                return RUN_MAX;
            return int'(v);
        endfunction

        // advance the model by one received byte
        function void take_byte(logic [7:0] b);
            int      hl;
            int      tl;
            int      i;
            int      n;
            sample_t s;
            hl = run_limit(hdr_len);
            tl = run_limit(tl_len);

            // hunting for the header run
            if (!in_pkt)
            begin
                if (b == hdr_byte)
                begin
                    hdr_run++;
                    if (hdr_run >= hl)
                    begin
                        in_pkt    = 1;
                        hdr_run   = 0;
                        tl_run    = 0;
                        pay_count = 0;
                    end
                end
                else
                begin
                    hdr_run = 0;
                end
                return;
            end

            // collect payload, count saturates on overlong packets
            if (pay_count < PAYLOAD_MAX)
                pay_mem[pay_count] = b;
            if (pay_count < COUNT_CAP)
                pay_count++;

            if (b != tl_byte)
            begin
                tl_run = 0;
                return;
            end
            tl_run++;
            if (tl_run < tl)
                return;

            // tail complete: emit samples only for the right length
            if (pay_count < COUNT_CAP && pay_count >= tl &&
                exp_bytes >= 1 && exp_bytes <= PAYLOAD_MAX &&
                pay_count - tl == exp_bytes)
            begin
                n = 0;
                for (i = int'(smp_offset); i + 1 < exp_bytes && n < MAX_RESULTS; i += 2)
                begin
                    s.packet_id    = pay_mem[0];
                    s.sample_index = n[4:0];
                    s.sample_value = {pay_mem[i + 1], pay_mem[i]};
                    s.last_sample  = !((i + 3 < exp_bytes) && (n + 1 < MAX_RESULTS));
                    pending_samples = {pending_samples, s};
                    n++;
                end
            end
            in_pkt    = 0;
            hdr_run   = 0;
            tl_run    = 0;
            pay_count = 0;
        endfunction

        // compare one sample word against the oldest expected one
        function void check_sample(sample_t got);
            sample_t want;
            if (pending_samples.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("unexpected sample word: id=%0d idx=%0d value=%0d last=%0b",
                             got.packet_id, got.sample_index, got.sample_value,
                             got.last_sample);
                return;
            end
            want = pending_samples.pop_front();
            if (got.packet_id !== want.packet_id ||
                got.sample_index !== want.sample_index ||
                got.sample_value !== want.sample_value ||
                got.last_sample !== want.last_sample)
            begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display({"sample word differs: expected id=%0d idx=%0d value=%0d ",
                              "last=%0b, got id=%0d idx=%0d value=%0d last=%0b"},
                             want.packet_id, want.sample_index, want.sample_value,
                             want.last_sample, got.packet_id, got.sample_index,
                             got.sample_value, got.last_sample);
            end
        endfunction
    endclass

    localparam logic [7:0] OPENING [0:26] = '{
        8'h00, 8'hFF, 8'h12, 8'hFF, 8'hFF,
        8'hA7, 8'h00,
        8'h00, 8'h80, 8'hFF, 8'h7F, 8'hFF, 8'hFF, 8'h00, 8'h00,
        8'h01, 8'h00, 8'hFE, 8'h01, 8'h34, 8'h12, 8'h55, 8'hAA,
        8'h0F, 8'hF0,
        8'hFE, 8'hFE
    };

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_write;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  in_valid;
    logic                  in_ready;
    logic [7:0]            rx_byte;
    logic                  out_valid;
    logic                  out_ready;
    logic [7:0]            packet_id;
    logic [4:0]            sample_index;
    logic signed [15:0]    sample_value;
    logic                  last_sample;

    sample_scoreboard board = new();
    int bytes_sent;
    int burst_left;

    sensor_packet_deframer DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .rx_byte      (rx_byte),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .packet_id    (packet_id),
        .sample_index (sample_index),
        .sample_value (sample_value),
        .last_sample  (last_sample)
    );

    always #6 clk = ~clk;

    // sample words leaving the block
    always @(posedge clk)
    begin : watch_samples
        sample_t got;
        if (rst_n && out_valid && out_ready)
        begin
            got.packet_id    = packet_id;
            got.sample_index = sample_index;
            got.sample_value = sample_value;
            got.last_sample  = last_sample;
            board.check_sample(got);
        end
    end

    // sink stalls: runs of full rate, coin flips, regular holes and long stalls
    initial
    begin : sink_stalls
        int mode;
        int span;
        int k;
        out_ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            mode = $urandom_range(0, 3);
            span = $urandom_range(8, 60);
            for (k = 0; k < span; k++)
            begin
                @(negedge clk);
                case (mode)
                    0: out_ready <= 1'b1;
                    1: out_ready <= 1'($urandom_range(0, 1));
                    2: out_ready <= (k % 4 != 3);
                    default: out_ready <= ($urandom_range(0, 7) == 0);
                endcase
            end
        end
    end

    // one byte word through the input handshake, in bursts with gaps
    task automatic push_byte(input logic [7:0] b);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 60)
                                                     : $urandom_range(1, 16);
        end
        burst_left--;
        in_valid <= 1'b1;
        rx_byte  <= b;
        do
            @(posedge clk);
        while (!in_ready);
        board.take_byte(b);
        bytes_sent++;
        @(negedge clk);
    endtask

    task automatic send_run(input logic [7:0] b, input int count);
        repeat (count) push_byte(b);
    endtask

    // random payload that never completes a tail run early
    task automatic send_payload(input int len);
        int         tl;
        int         tail_seen;
        int         k;
        logic [7:0] b;
        tl        = board.run_limit(board.tl_len);
        tail_seen = 0;
        for (k = 0; k < len; k++)
        begin
            b = ($urandom_range(0, 7) == 0) ? board.tl_byte : 8'($urandom_range(0, 255));
            if (b == board.tl_byte)
                tail_seen++;
            else
                tail_seen = 0;
            if (tail_seen >= tl)
            begin
                b         = board.tl_byte + 8'd1;
                tail_seen = 0;
            end
            push_byte(b);
        end
    endtask

    task automatic send_packet(input int len);
        send_run(board.hdr_byte, board.run_limit(board.hdr_len));
        send_payload(len);
        send_run(board.tl_byte, board.run_limit(board.tl_len));
    endtask

    // line noise, then a tail run to close anything it opened
    task automatic send_noise();
        repeat ($urandom_range(1, 8)) push_byte(8'($urandom_range(0, 255)));
        push_byte(board.hdr_byte ^ 8'h01);
        send_run(board.tl_byte, board.run_limit(board.tl_len));
    endtask

    // mostly well-formed packets, some broken ones and noise
    task automatic run_phase(input int budget);
        int start;
        int pick;
        int exp_len;
        int len;
        start = bytes_sent;
        while (bytes_sent - start < budget)
        begin
            pick    = $urandom_range(0, 9);
            exp_len = int'(board.exp_bytes);
            if (pick == 9)
            begin
                send_noise();
            end
            else
            begin
                if (pick == 8)
                    len = $urandom_range(70, 80);
                else if (pick == 7)
                    len = $urandom_range(0, 6);
                else if (pick == 6)
                    len = exp_len + int'($urandom_range(0, 2)) - 1;
                else if (exp_len >= 1 && exp_len <= PAYLOAD_MAX)
                    len = exp_len;
                else
                    len = $urandom_range(0, 70);
                if (len < 0)
                    len = 0;
                send_packet(len);
            end
        end
    endtask

    // wait for every expected sample, then let a dropped packet finish
    task automatic settle();
        in_valid <= 1'b0;
        while (board.pending_samples.size() != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
        burst_left = 0;
    endtask

    task automatic write_reg(input cfg_reg_t r, input logic [7:0] v);
        cfg_write <= 1'b1;
        cfg_index <= r;
        cfg_data  <= v;
        @(negedge clk);
        board.set_reg(r, v);
    endtask

    task automatic set_config(input logic [7:0] hb, input logic [7:0] hl,
                              input logic [7:0] tb, input logic [7:0] tl,
                              input logic [7:0] eb, input logic [7:0] so);
        write_reg(REG_HEADER_BYTE, hb);
        write_reg(REG_HEADER_LENGTH, hl);
        write_reg(REG_TAIL_BYTE, tb);
        write_reg(REG_TAIL_LENGTH, tl);
        write_reg(REG_EXPECTED_BYTES, eb);
        write_reg(REG_SAMPLE_OFFSET, so);
        cfg_write <= 1'b0;
    endtask

    // run limit
    initial
    begin
        #5_000_000;
        $display("sensor_packet_deframer: mismatch");
        $finish;
    end

    initial
    begin : stimulus
        int k;
        int hl;
        int tl;
        int eb;
        int so;
        rst_n      = 1'b0;
        cfg_write  = 1'b0;
        cfg_index  = REG_HEADER_BYTE;
        cfg_data   = '0;
        in_valid   = 1'b0;
        rx_byte    = '0;
        bytes_sent = 0;
        burst_left = 0;
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset settings: broken header, then one packet with extreme samples
        for (k = 0; k < 27; k++)
            push_byte(OPENING[k]);
        settle();

        // one-byte packets with no complete sample, shortest runs
        set_config(8'h00, 8'd1, 8'hFF, 8'd1, 8'd1, 8'd0);
        run_phase(40);
        settle();
        // longest runs, full payload, full sample count
        set_config(8'hA5, 8'd8, 8'h5A, 8'd8, 8'd64, 8'd0);
        run_phase(40);
        settle();
        // zero and over-range runs, header equals tail, offset past the end
        set_config(8'h55, 8'd0, 8'h55, 8'd15, 8'd64, 8'd63);
        run_phase(40);
        settle();
        // zero expected length never matches
        set_config(8'hFF, 8'd15, 8'h00, 8'd0, 8'd0, 8'd0);
        run_phase(40);
        settle();
        // expected length past the store never matches
        set_config(8'h3C, 8'd3, 8'hC3, 8'd2, 8'd127, 8'd5);
        run_phase(40);
        settle();
        // single-sample packets, header equals tail
        set_config(8'h7E, 8'd1, 8'h7E, 8'd1, 8'd2, 8'd0);
        run_phase(40);
        settle();
        // odd length with odd offset
        set_config(8'h10, 8'd4, 8'h20, 8'd3, 8'd33, 8'd1);
        run_phase(40);
        settle();

        // random settings, mostly short packets
        while (bytes_sent < TARGET_BYTES)
        begin
            hl = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 15) : $urandom_range(1, 4);
            tl = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 15) : $urandom_range(1, 4);
            eb = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 127) : $urandom_range(1, 24);
            so = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 63) : $urandom_range(0, 4);
            set_config(8'($urandom_range(0, 255)), 8'(hl), 8'($urandom_range(0, 255)),
                       8'(tl), 8'(eb), 8'(so));
            run_phase(60);
            settle();
        end

        if (board.mismatches == 0 && board.pending_samples.size() == 0)
            $display("sensor_packet_deframer: match");
        else
            $display("sensor_packet_deframer: mismatch");
        $finish;
    end

endmodule

`default_nettype wire

// File: sensor_packet_deframer.f
src/spd_pkg.sv
src/spd_ram.sv
src/sensor_packet_deframer.sv
bench/tb.sv
